FILE: hw/rtl/mdt_pkg.sv
// Shared widths, register indexes and reset values for the debounce/toggle core.
package mdt_pkg;

  localparam int unsigned LevelW  = 16;
  localparam int unsigned TicksW  = 16;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDatW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    RegDebounceTicks = 8'd0,
    RegManualMode    = 8'd1
  } cfg_reg_e;

  localparam logic [TicksW-1:0] DebounceTicksRst = 16'd100;
  localparam logic              ManualModeRst    = 1'b1;
  localparam logic [TicksW-1:0] TicksMax         = 16'hFFFF;

endpackage

FILE: hw/rtl/multi_input_debounce_toggle_core.sv
// Multi-channel switch debouncer with a toggle latch per channel.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o): one request per millisecond tick,
//   carrying one raw sample bit per channel in raw_levels_i.
//   Output channel (out_valid_o / out_stall_i): one request per input tick,
//   carrying the accepted levels and toggle bits after that tick's update.
//   Configuration channel (cfg_valid_i / cfg_ready_o): index 0 writes the
//   debounce limit in ticks, index 1 the manual (toggle) mode bit. Other
//   indexes are dropped. Write only while the core is idle.
// Pipeline: a tick's result is registered and shows from the cycle after it
//   is accepted; one tick per cycle is taken while out_stall_i does not hold
//   a waiting result. A single register stage holds the per-channel state and
//   also serves as the output register.
// Reset: all levels, toggle bits, timers and edge counts clear; the limit
//   returns to 100 ticks and manual mode is on.
// Stall: while a result waits under out_stall_i, in_stall_o is raised and
//   the state holds, so the waiting result does not change.
module multi_input_debounce_toggle_core #(
  parameter int unsigned CHANNELS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [mdt_pkg::LevelW-1:0]   raw_levels_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [mdt_pkg::LevelW-1:0]   stable_levels_o,
  output logic [mdt_pkg::LevelW-1:0]   toggle_states_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [mdt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mdt_pkg::CfgDatW-1:0]  cfg_data_i
);

  localparam int unsigned TW = mdt_pkg::TicksW;

  // Configuration registers
  logic [TW-1:0] debounce_ticks_q;
  logic          manual_mode_q;

  // Per-channel state; the level and toggle vectors double as output payload
  logic [CHANNELS-1:0] level_q, level_d;
  logic [CHANNELS-1:0] toggle_q, toggle_d;
  logic [CHANNELS-1:0] run_q, run_d;
  logic [CHANNELS-1:0] edge_q, edge_d;
  logic [TW-1:0]       elapsed_q [CHANNELS];
  logic [TW-1:0]       elapsed_d [CHANNELS];

  logic out_valid_q;
  logic in_accept;

  // Hold the input while a finished result still waits under stall
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ticks_q <= mdt_pkg::DebounceTicksRst;
      manual_mode_q    <= mdt_pkg::ManualModeRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        mdt_pkg::RegDebounceTicks: debounce_ticks_q <= cfg_data_i[TW-1:0];
        mdt_pkg::RegManualMode:    manual_mode_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Per-channel debounce update; channels are independent
  always_comb begin
    logic [TW-1:0] elapsed_inc;
    logic          expired;
    logic          differs;
    level_d  = level_q;
    toggle_d = toggle_q;
    run_d    = run_q;
    edge_d   = edge_q;
    for (int i = 0; i < CHANNELS; i++) begin
      elapsed_d[i] = elapsed_q[i];
      // Advance a running timer, saturating at its top
      elapsed_inc = (elapsed_q[i] == mdt_pkg::TicksMax) ? elapsed_q[i]
                                                        : elapsed_q[i] + 1'b1;
      expired = run_q[i] && (elapsed_inc >= debounce_ticks_q);
      differs = raw_levels_i[i] != level_q[i];
      if (run_q[i]) begin
        elapsed_d[i] = elapsed_inc;
      end
      if (differs) begin
        if (!run_q[i]) begin
          // Start the timer on a fresh disagreement
          run_d[i]     = 1'b1;
          elapsed_d[i] = '0;
        end else if (expired) begin
          // Accept the new level; in manual mode every second change flips the toggle
          level_d[i] = ~level_q[i];
          if (manual_mode_q) begin
            if (edge_q[i]) begin
              toggle_d[i] = ~toggle_q[i];
              edge_d[i]   = 1'b0;
            end else begin
              edge_d[i] = 1'b1;
            end
          end
          run_d[i]     = 1'b0;
          elapsed_d[i] = '0;
        end
      end else if (expired) begin
        // Bounce settled back: drop the half-counted edge
        edge_d[i]    = 1'b0;
        run_d[i]     = 1'b0;
        elapsed_d[i] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= '0;
      toggle_q    <= '0;
      run_q       <= '0;
      edge_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        elapsed_q[i] <= '0;
      end
    end else begin
      if (in_accept) begin
        level_q   <= level_d;
        toggle_q  <= toggle_d;
        run_q     <= run_d;
        edge_q    <= edge_d;
        elapsed_q <= elapsed_d;
      end
      if (in_accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stable_levels_o = mdt_pkg::LevelW'(level_q);
  assign toggle_states_o = mdt_pkg::LevelW'(toggle_q);

  // State holds while the input is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> ($stable(level_q) && $stable(toggle_q) && $stable(run_q)))
    else $error("state changed while stalled");

  // Every accepted tick leaves a result pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_o)
    else $error("accepted tick gave no result");

  // A level only changes on the tick its timer stops
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (((level_q ^ $past(level_q)) & ~($past(run_q) & ~run_q)) == '0))
    else $error("level changed without an expiring timer");

  // A stopped timer on channel 0 always reads zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !run_q[0] |-> (elapsed_q[0] == '0))
    else $error("stopped timer not cleared");

  // The toggle bit only flips when the level changes too
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (((toggle_q ^ $past(toggle_q)) & ~(level_q ^ $past(level_q))) == '0))
    else $error("toggle flipped without an accepted change");

endmodule
